[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SBEH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbeh: assertion failed");

// Next-cycle implication
`define SBEH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbeh: assertion failed");

`endif

[src/sbeh_pkg.sv]
// ----------------------------------------------------------------------------
// sbeh_pkg
// Widths, face codes and divider sideband type for the segment/box edge hit.
// ----------------------------------------------------------------------------
package sbeh_pkg;

    localparam int COORD_BITS = 15;
    localparam int SIZE_W     = 14;
    localparam int OUT_W      = 16;

    // box right / top coordinate
    localparam int EXT_W = ((COORD_BITS > SIZE_W + 1) ? COORD_BITS : SIZE_W + 1) + 1;
    // coordinate differences
    localparam int DIF_W = EXT_W + 1;
    // cross-product terms and their difference
    localparam int PRD_W = 2 * DIF_W;
    localparam int CRS_W = PRD_W + 1;
    // divider: quotient magnitude never exceeds |delta| on a hit
    localparam int QUO_W = COORD_BITS + 1;
    localparam int DVD_W = 2 * DIF_W;
    // final coordinate sum
    localparam int SUM_W = (EXT_W + 1 > OUT_W) ? EXT_W + 1 : OUT_W;

    typedef enum logic [1:0] {
        EDGE_BOTTOM = 2'd0,
        EDGE_TOP    = 2'd1,
        EDGE_LEFT   = 2'd2,
        EDGE_RIGHT  = 2'd3
    } face_t;

    // Travels with each transaction through the divider
    typedef struct packed {
        logic                   hit;
        face_t                  face;
        logic                   horiz;
        logic                   neg;
        logic [COORD_BITS-1:0]  start;
        logic [EXT_W-1:0]       edge_pos;
    } div_side_t;

endpackage

[src/sbeh_div.sv]
// ----------------------------------------------------------------------------
// sbeh_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module sbeh_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sbeh_pkg::DVD_W-1:0]  dividend,
    input  logic [sbeh_pkg::DIF_W-1:0]  divisor,
    input  sbeh_pkg::div_side_t         in_side,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sbeh_pkg::QUO_W-1:0]  quotient,
    output sbeh_pkg::div_side_t         out_side
);
    import sbeh_pkg::*;

    localparam int NSTG = QUO_W;

    logic [NSTG-1:0]    vld_reg;
    logic [NSTG:0]      rdy;
    logic [DVD_W-1:0]   rem_reg  [NSTG];
    logic [QUO_W-1:0]   quo_reg  [NSTG];
    logic [DIF_W-1:0]   dvs_reg  [NSTG];
    div_side_t          side_reg [NSTG];

    // stage k may load when empty or when its successor moves
    always_comb
    begin
        rdy[NSTG] = !out_stall;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_stall = !rdy[0];

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stg
        logic [DVD_W-1:0]   rem_in;
        logic [DVD_W-1:0]   rem_next;
        logic [DVD_W-1:0]   shf;
        logic [QUO_W-1:0]   quo_in;
        logic [QUO_W-1:0]   quo_next;
        logic [DIF_W-1:0]   dvs_in;
        div_side_t          side_in;
        logic               vld_in;

        if (k == 0)
        begin : g_head
            assign rem_in  = dividend;
            assign quo_in  = '0;
            assign dvs_in  = divisor;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else
        begin : g_body
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // one compare-subtract for quotient bit QUO_W-1-k
        always_comb
        begin
            shf      = DVD_W'(dvs_in) << (QUO_W - 1 - k);
            quo_next = quo_in;
            if (rem_in >= shf)
            begin
                rem_next                 = rem_in - shf;
                quo_next[QUO_W - 1 - k]  = 1'b1;
            end
            else
            begin
                rem_next = rem_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                dvs_reg[k]  <= dvs_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign quotient  = quo_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

[src/segment_box_edge_hit.sv]
// ----------------------------------------------------------------------------
// segment_box_edge_hit
// Segment versus axis-aligned box edge crossing with exact integer math.
// ----------------------------------------------------------------------------
// Stages from query to result: six front stages, one divider stage per
//   quotient bit, one output stage.
// Throughput: one transaction per cycle when not stalled; stalls back up
//   stage by stage and empty stages fill, so bubbles are squeezed out.
// Reset: rst_n clears every stage valid bit; the data path is not reset.
module segment_box_edge_hit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                query_valid,
    output logic                                query_stall,
    input  logic signed [sbeh_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [sbeh_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [sbeh_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [sbeh_pkg::COORD_BITS-1:0] end_y,
    input  logic signed [sbeh_pkg::COORD_BITS-1:0] box_x,
    input  logic signed [sbeh_pkg::COORD_BITS-1:0] box_y,
    input  logic [sbeh_pkg::SIZE_W-1:0]         box_width,
    input  logic [sbeh_pkg::SIZE_W-1:0]         box_height,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                hit,
    output logic [1:0]                          face,
    output logic signed [sbeh_pkg::OUT_W-1:0]   cross_x,
    output logic signed [sbeh_pkg::OUT_W-1:0]   cross_y
);
    import sbeh_pkg::*;

    function automatic logic [DIF_W-1:0] mag_of(input logic signed [DIF_W-1:0] v);
        logic [DIF_W-1:0] r;
        r = v[DIF_W-1] ? DIF_W'(-v) : DIF_W'(v);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshake chain
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, ovld_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_o;
    logic div_in_stall;
    logic div_out_valid;

    assign rdy_o       = !ovld_reg || !result_stall;
    assign rdy6        = !v6_reg || !div_in_stall;
    assign rdy5        = !v5_reg || rdy6;
    assign rdy4        = !v4_reg || rdy5;
    assign rdy3        = !v3_reg || rdy4;
    assign rdy2        = !v2_reg || rdy3;
    assign rdy1        = !v1_reg || rdy2;
    assign query_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)  v1_reg   <= query_valid;
            if (rdy2)  v2_reg   <= v1_reg;
            if (rdy3)  v3_reg   <= v2_reg;
            if (rdy4)  v4_reg   <= v3_reg;
            if (rdy5)  v5_reg   <= v4_reg;
            if (rdy6)  v6_reg   <= v5_reg;
            if (rdy_o) ovld_reg <= div_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: box far corner, segment deltas
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] s1_px_reg, s1_py_reg, s1_qx_reg, s1_qy_reg;
    logic signed [COORD_BITS-1:0] s1_bx_reg, s1_by_reg;
    logic signed [EXT_W-1:0]      s1_rgt_reg, s1_tp_reg, s1_rgt_next, s1_tp_next;
    logic signed [DIF_W-1:0]      s1_dx_reg, s1_dy_reg, s1_dx_next, s1_dy_next;
    logic                         s1_wnz_reg, s1_hnz_reg;

    always_comb
    begin
        s1_rgt_next = EXT_W'(box_x) + EXT_W'(box_width);
        s1_tp_next  = EXT_W'(box_y) + EXT_W'(box_height);
        s1_dx_next  = DIF_W'(end_x) - DIF_W'(start_x);
        s1_dy_next  = DIF_W'(end_y) - DIF_W'(start_y);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_px_reg  <= start_x;
            s1_py_reg  <= start_y;
            s1_qx_reg  <= end_x;
            s1_qy_reg  <= end_y;
            s1_bx_reg  <= box_x;
            s1_by_reg  <= box_y;
            s1_rgt_reg <= s1_rgt_next;
            s1_tp_reg  <= s1_tp_next;
            s1_dx_reg  <= s1_dx_next;
            s1_dy_reg  <= s1_dy_next;
            s1_wnz_reg <= (box_width != '0);
            s1_hnz_reg <= (box_height != '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick candidate edges, edge-relative differences
    // ------------------------------------------------------------------
    logic                         s2_bot_next, s2_topc, s2_lft_next, s2_rgc;
    logic signed [EXT_W-1:0]      s2_eh_next, s2_ev_next;
    logic signed [DIF_W-1:0]      s2_a1_next, s2_a2_next, s2_hq_next, s2_hp_next, s2_nh_next;
    logic signed [DIF_W-1:0]      s2_b1_next, s2_b2_next, s2_vq_next, s2_vp_next, s2_nv_next;

    logic                         s2_bot_reg, s2_lft_reg, s2_candh_reg, s2_candv_reg;
    logic                         s2_wnz_reg, s2_hnz_reg;
    logic signed [COORD_BITS-1:0] s2_px_reg, s2_py_reg;
    logic signed [EXT_W-1:0]      s2_eh_reg, s2_ev_reg;
    logic signed [DIF_W-1:0]      s2_dx_reg, s2_dy_reg;
    logic signed [DIF_W-1:0]      s2_a1_reg, s2_a2_reg, s2_hq_reg, s2_hp_reg, s2_nh_reg;
    logic signed [DIF_W-1:0]      s2_b1_reg, s2_b2_reg, s2_vq_reg, s2_vp_reg, s2_nv_reg;

    always_comb
    begin
        s2_bot_next = s1_py_reg <= s1_by_reg;
        s2_topc     = EXT_W'(s1_py_reg) >= s1_tp_reg;
        s2_lft_next = s1_px_reg <= s1_bx_reg;
        s2_rgc      = EXT_W'(s1_px_reg) >= s1_rgt_reg;
        s2_eh_next  = s2_bot_next ? EXT_W'(s1_by_reg) : s1_tp_reg;
        s2_ev_next  = s2_lft_next ? EXT_W'(s1_bx_reg) : s1_rgt_reg;
        // horizontal edge
        s2_a1_next  = DIF_W'(s1_bx_reg)  - DIF_W'(s1_qx_reg);
        s2_a2_next  = DIF_W'(s1_rgt_reg) - DIF_W'(s1_qx_reg);
        s2_hq_next  = DIF_W'(s2_eh_next) - DIF_W'(s1_qy_reg);
        s2_hp_next  = DIF_W'(s2_eh_next) - DIF_W'(s1_py_reg);
        s2_nh_next  = DIF_W'(s1_py_reg)  - DIF_W'(s2_eh_next);
        // vertical edge
        s2_b1_next  = DIF_W'(s1_by_reg)  - DIF_W'(s1_qy_reg);
        s2_b2_next  = DIF_W'(s1_tp_reg)  - DIF_W'(s1_qy_reg);
        s2_vq_next  = DIF_W'(s2_ev_next) - DIF_W'(s1_qx_reg);
        s2_vp_next  = DIF_W'(s2_ev_next) - DIF_W'(s1_px_reg);
        s2_nv_next  = DIF_W'(s1_px_reg)  - DIF_W'(s2_ev_next);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_bot_reg   <= s2_bot_next;
            s2_lft_reg   <= s2_lft_next;
            s2_candh_reg <= s2_bot_next || s2_topc;
            s2_candv_reg <= s2_lft_next || s2_rgc;
            s2_wnz_reg   <= s1_wnz_reg;
            s2_hnz_reg   <= s1_hnz_reg;
            s2_px_reg    <= s1_px_reg;
            s2_py_reg    <= s1_py_reg;
            s2_eh_reg    <= s2_eh_next;
            s2_ev_reg    <= s2_ev_next;
            s2_dx_reg    <= s1_dx_reg;
            s2_dy_reg    <= s1_dy_reg;
            s2_a1_reg    <= s2_a1_next;
            s2_a2_reg    <= s2_a2_next;
            s2_hq_reg    <= s2_hq_next;
            s2_hp_reg    <= s2_hp_next;
            s2_nh_reg    <= s2_nh_next;
            s2_b1_reg    <= s2_b1_next;
            s2_b2_reg    <= s2_b2_next;
            s2_vq_reg    <= s2_vq_next;
            s2_vp_reg    <= s2_vp_next;
            s2_nv_reg    <= s2_nv_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: orientation products, edge-line side tests
    // ------------------------------------------------------------------
    logic signed [PRD_W-1:0]      s3_ph1_next, s3_ph2_next, s3_phe_next;
    logic signed [PRD_W-1:0]      s3_pv1_next, s3_pve1_next, s3_pve2_next;
    logic                         s3_okh_next, s3_okv_next;

    logic signed [PRD_W-1:0]      s3_ph1_reg, s3_ph2_reg, s3_phe_reg;
    logic signed [PRD_W-1:0]      s3_pv1_reg, s3_pve1_reg, s3_pve2_reg;
    logic                         s3_okh_reg, s3_okv_reg, s3_bot_reg, s3_lft_reg;
    logic signed [COORD_BITS-1:0] s3_px_reg, s3_py_reg;
    logic signed [EXT_W-1:0]      s3_eh_reg, s3_ev_reg;
    logic signed [DIF_W-1:0]      s3_dx_reg, s3_dy_reg, s3_nh_reg, s3_nv_reg;

    always_comb
    begin
        s3_ph1_next  = s2_dy_reg * s2_a1_reg;
        s3_ph2_next  = s2_dy_reg * s2_a2_reg;
        s3_phe_next  = s2_dx_reg * s2_hq_reg;
        s3_pv1_next  = s2_dy_reg * s2_vq_reg;
        s3_pve1_next = s2_dx_reg * s2_b1_reg;
        s3_pve2_next = s2_dx_reg * s2_b2_reg;
        // both segment ends strictly on one side of the edge line rejects
        s3_okh_next  = s2_candh_reg && s2_wnz_reg && (s2_dy_reg != '0)
                       && !((s2_hp_reg > 0 && s2_hq_reg > 0)
                         || (s2_hp_reg < 0 && s2_hq_reg < 0));
        s3_okv_next  = s2_candv_reg && s2_hnz_reg && (s2_dx_reg != '0)
                       && !((s2_vp_reg > 0 && s2_vq_reg > 0)
                         || (s2_vp_reg < 0 && s2_vq_reg < 0));
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_ph1_reg  <= s3_ph1_next;
            s3_ph2_reg  <= s3_ph2_next;
            s3_phe_reg  <= s3_phe_next;
            s3_pv1_reg  <= s3_pv1_next;
            s3_pve1_reg <= s3_pve1_next;
            s3_pve2_reg <= s3_pve2_next;
            s3_okh_reg  <= s3_okh_next;
            s3_okv_reg  <= s3_okv_next;
            s3_bot_reg  <= s2_bot_reg;
            s3_lft_reg  <= s2_lft_reg;
            s3_px_reg   <= s2_px_reg;
            s3_py_reg   <= s2_py_reg;
            s3_eh_reg   <= s2_eh_reg;
            s3_ev_reg   <= s2_ev_reg;
            s3_dx_reg   <= s2_dx_reg;
            s3_dy_reg   <= s2_dy_reg;
            s3_nh_reg   <= s2_nh_reg;
            s3_nv_reg   <= s2_nv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: cross products, edge ends against the segment line
    // ------------------------------------------------------------------
    logic signed [CRS_W-1:0]      s4_c1h, s4_c2h, s4_c1v, s4_c2v;
    logic                         s4_hith_next, s4_hitv_next;

    logic                         s4_hith_reg, s4_hitv_reg, s4_bot_reg, s4_lft_reg;
    logic signed [COORD_BITS-1:0] s4_px_reg, s4_py_reg;
    logic signed [EXT_W-1:0]      s4_eh_reg, s4_ev_reg;
    logic signed [DIF_W-1:0]      s4_dx_reg, s4_dy_reg, s4_nh_reg, s4_nv_reg;

    always_comb
    begin
        s4_c1h       = CRS_W'(s3_ph1_reg) - CRS_W'(s3_phe_reg);
        s4_c2h       = CRS_W'(s3_ph2_reg) - CRS_W'(s3_phe_reg);
        s4_c1v       = CRS_W'(s3_pv1_reg) - CRS_W'(s3_pve1_reg);
        s4_c2v       = CRS_W'(s3_pv1_reg) - CRS_W'(s3_pve2_reg);
        s4_hith_next = s3_okh_reg && !((s4_c1h > 0 && s4_c2h > 0)
                                    || (s4_c1h < 0 && s4_c2h < 0));
        s4_hitv_next = s3_okv_reg && !((s4_c1v > 0 && s4_c2v > 0)
                                    || (s4_c1v < 0 && s4_c2v < 0));
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_hith_reg <= s4_hith_next;
            s4_hitv_reg <= s4_hitv_next;
            s4_bot_reg  <= s3_bot_reg;
            s4_lft_reg  <= s3_lft_reg;
            s4_px_reg   <= s3_px_reg;
            s4_py_reg   <= s3_py_reg;
            s4_eh_reg   <= s3_eh_reg;
            s4_ev_reg   <= s3_ev_reg;
            s4_dx_reg   <= s3_dx_reg;
            s4_dy_reg   <= s3_dy_reg;
            s4_nh_reg   <= s3_nh_reg;
            s4_nv_reg   <= s3_nv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: choose edge, operand magnitudes and quotient sign
    // ------------------------------------------------------------------
    logic signed [DIF_W-1:0]      s5_n, s5_d, s5_den;
    div_side_t                    s5_side_next, s5_side_reg;
    logic [DIF_W-1:0]             s5_mn_reg, s5_md_reg, s5_mv_reg;

    always_comb
    begin
        // horizontal: x = px + (py-e)*dx/(py-qy); vertical: y = py + (px-e)*dy/(px-qx)
        s5_n   = s4_hith_reg ? s4_nh_reg : s4_nv_reg;
        s5_d   = s4_hith_reg ? s4_dx_reg : s4_dy_reg;
        s5_den = s4_hith_reg ? s4_dy_reg : s4_dx_reg;   // divisor is the negated delta
        s5_side_next.hit      = s4_hith_reg || s4_hitv_reg;
        s5_side_next.horiz    = s4_hith_reg;
        s5_side_next.neg      = (s5_n < 0) ^ (s5_d < 0) ^ (s5_den > 0);
        s5_side_next.start    = s4_hith_reg ? s4_px_reg : s4_py_reg;
        s5_side_next.edge_pos = s4_hith_reg ? s4_eh_reg : s4_ev_reg;
        if (s4_hith_reg)
        begin
            s5_side_next.face = s4_bot_reg ? EDGE_BOTTOM : EDGE_TOP;
        end
        else
        begin
            s5_side_next.face = s4_lft_reg ? EDGE_LEFT : EDGE_RIGHT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            s5_side_reg <= s5_side_next;
            s5_mn_reg   <= mag_of(s5_n);
            s5_md_reg   <= mag_of(s5_d);
            s5_mv_reg   <= mag_of(s5_den);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: dividend product
    // ------------------------------------------------------------------
    logic [DVD_W-1:0]             s6_prod_reg;
    logic [DIF_W-1:0]             s6_mv_reg;
    div_side_t                    s6_side_reg;

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            s6_prod_reg <= DVD_W'(s5_mn_reg) * DVD_W'(s5_md_reg);
            s6_mv_reg   <= s5_mv_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    logic [QUO_W-1:0]             div_quo;
    div_side_t                    div_side;

    sbeh_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .in_stall  (div_in_stall),
        .dividend  (s6_prod_reg),
        .divisor   (s6_mv_reg),
        .in_side   (s6_side_reg),
        .out_valid (div_out_valid),
        .out_stall (!rdy_o),
        .quotient  (div_quo),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Output stage: signed offset added to the start coordinate
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]             fo_q, fo_start, fo_edge, fo_sum;
    logic                         hit_reg;
    face_t                        face_reg;
    logic [OUT_W-1:0]             cx_reg, cy_reg, cx_next, cy_next;

    always_comb
    begin
        fo_q     = SUM_W'(div_quo);
        fo_q     = div_side.neg ? SUM_W'(-fo_q) : fo_q;
        fo_start = {{(SUM_W - COORD_BITS){div_side.start[COORD_BITS-1]}}, div_side.start};
        fo_edge  = {{(SUM_W - EXT_W){div_side.edge_pos[EXT_W-1]}}, div_side.edge_pos};
        fo_sum   = fo_start + fo_q;
        cx_next  = '0;
        cy_next  = '0;
        if (div_side.hit)
        begin
            cx_next = div_side.horiz ? fo_sum[OUT_W-1:0] : fo_edge[OUT_W-1:0];
            cy_next = div_side.horiz ? fo_edge[OUT_W-1:0] : fo_sum[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_o)
        begin
            hit_reg  <= div_side.hit;
            face_reg <= div_side.hit ? div_side.face : EDGE_BOTTOM;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
        end
    end

    assign result_valid = ovld_reg;
    assign hit          = hit_reg;
    assign face         = face_reg;
    assign cross_x      = cx_reg;
    assign cross_y      = cy_reg;

endmodule

[src/sbeh_chk.sv]
// ----------------------------------------------------------------------------
// sbeh_chk
// Port-level checks for segment_box_edge_hit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbeh_chk
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              query_stall,
    input logic                              result_valid,
    input logic                              result_stall,
    input logic                              hit,
    input logic [1:0]                        face,
    input logic signed [sbeh_pkg::OUT_W-1:0] cross_x,
    input logic signed [sbeh_pkg::OUT_W-1:0] cross_y
);
    import sbeh_pkg::*;

    logic                   res_zero;
    logic [2*OUT_W+2:0]     res_fields;

    assign res_zero   = (face == EDGE_BOTTOM) && (cross_x == '0) && (cross_y == '0);
    assign res_fields = {hit, face, cross_x, cross_y};

    // a miss reports all-zero fields
    `SBEH_ASSERT_NOW(a_miss_zero, result_valid && !hit, res_zero)

    // input backpressure only comes from a blocked result
    `SBEH_ASSERT_NOW(a_stall_cause, query_stall, result_valid && result_stall)

    // a stalled result holds
    `SBEH_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(res_fields))

endmodule

bind segment_box_edge_hit sbeh_chk u_sbeh_chk (.*);
